>>> src/assert_macros.svh
// Assertion macros shared by the table unit's modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  `ASSERT_CLK(lbl, clk, rst, (ante) |-> (cons), msg)

// Check that a consequent holds in the cycle after its antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  `ASSERT_CLK(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

>>> src/sktt_pkg.sv
// Types and constants of the sorted key toggle table unit
package sktt_pkg;

  localparam int KEY_W = 32;
  localparam int PCT_W = 7;
  localparam int IDX_W = 7;
  localparam int CNT_OUT_W = 8;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Request command codes
  localparam logic [1:0] CMD_TOGGLE = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key_primary;
    logic [KEY_W-1:0] key_secondary;
    logic [PCT_W-1:0] entry_percent;
    logic [IDX_W-1:0] entry_index;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [KEY_W-1:0]     out_primary;
    logic [KEY_W-1:0]     out_secondary;
    logic [PCT_W-1:0]     out_percent;
    logic [CNT_OUT_W-1:0] entry_count;
  } res_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_primary;
    logic [KEY_W-1:0] key_secondary;
    logic [PCT_W-1:0] percent;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT_DN,
    ST_DEC,
    ST_SHIFT_UP,
    ST_WRITE_NEW,
    ST_READ,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic step_up;
    logic step_down;
    logic cmp_en;
    logic shift_wr;
    logic prep_remove;
    logic prep_insert;
    logic write_new;
    logic cnt_inc;
    logic cnt_dec;
    logic read_idx;
    logic emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic       scan_found;
    logic       up_end;
    logic       down_end;
    logic       match;
    logic       pos_full;
    logic [1:0] command;
  } ctl_sts_t;

endpackage

>>> src/sorted_key_toggle_table_unit.sv
// Top level of the sorted key toggle table unit
//
//   channel   ports                    handshake
//   request   start, busy, request     taken when start is high and busy is low
//   result    done, result             shown for one cycle while done is high
//
// A toggle walks the table with one memory read per cycle up to the key's slot, then one
// moved entry per cycle from there to the end to close or open a gap, so the two walks
// together cross the table once. A find makes only the first walk, and a read makes a single
// memory read. The result is registered and comes as busy falls. Reset empties the table
// at once. The receiver cannot stall, so nothing holds the result back.

module sorted_key_toggle_table_unit #(
  parameter int CAPACITY = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  sktt_pkg::req_t  request,
  output logic            done,
  output sktt_pkg::res_t  result
);
  import sktt_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  sktt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (request.command),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  sktt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .sts     (sts),
    .done    (done),
    .result  (result)
  );

endmodule

>>> src/sktt_ctrl.sv
// Controller state machine of the sorted key toggle table unit
`include "assert_macros.svh"

module sktt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        command,
  input  sktt_pkg::ctl_sts_t sts,
  output logic              busy,
  output sktt_pkg::ctl_cmd_t cmd
);
  import sktt_pkg::*;

  state_t state;
  state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the walk over the table
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          case (command)
            CMD_TOGGLE, CMD_FIND: state_next = ST_SCAN;
            CMD_READ:             state_next = ST_READ;
            default:              state_next = ST_EMIT;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.step_up = 1'b1;
        cmd.cmp_en = 1'b1;
        if (sts.scan_found || sts.up_end) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.command != CMD_TOGGLE) begin
          state_next = ST_EMIT;
        end else if (sts.match) begin
          cmd.prep_remove = 1'b1;
          state_next = ST_SHIFT_DN;
        end else if (sts.pos_full) begin
          // drop the new key: it is the largest of a full table
          state_next = ST_EMIT;
        end else begin
          cmd.prep_insert = 1'b1;
          state_next = ST_SHIFT_UP;
        end
      end
      ST_SHIFT_DN: begin
        cmd.step_up = 1'b1;
        cmd.shift_wr = 1'b1;
        if (sts.up_end) begin
          state_next = ST_DEC;
        end
      end
      ST_DEC: begin
        cmd.cnt_dec = 1'b1;
        state_next = ST_EMIT;
      end
      ST_SHIFT_UP: begin
        cmd.step_down = 1'b1;
        cmd.shift_wr = 1'b1;
        if (sts.down_end) begin
          state_next = ST_WRITE_NEW;
        end
      end
      ST_WRITE_NEW: begin
        cmd.write_new = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next = ST_EMIT;
      end
      ST_READ: begin
        cmd.read_idx = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst, start && !busy, state != ST_IDLE, "accepted request left controller idle")

endmodule

>>> src/sktt_datapath.sv
// Datapath of the sorted key toggle table unit: entry memory, walk counters, result register
`include "assert_macros.svh"

module sktt_datapath #(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  sktt_pkg::req_t     request,
  input  sktt_pkg::ctl_cmd_t cmd,
  output sktt_pkg::ctl_sts_t sts,
  output logic               done,
  output sktt_pkg::res_t     result
);
  import sktt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  entry_t         mem [CAPACITY];
  entry_t         rdata;
  entry_t         wr_data;
  entry_t         found;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rv_addr;
  logic           wr_en;
  req_t           req;
  req_t           req_in;
  logic [CW-1:0]  count;
  logic [CW-1:0]  idx;
  logic [CW-1:0]  pos;
  logic [CW-1:0]  last;
  logic           rvalid;
  logic           match;
  logic           key_ge;
  logic           key_eq;
  logic [XW-1:0]  index_x;
  logic [XW-1:0]  count_x;
  logic           index_ok;
  res_t           res_next;

  assign index_x  = XW'(req.entry_index);
  assign count_x  = XW'(count);
  assign index_ok = index_x < count_x;
  assign last     = (count < CW'(CAPACITY)) ? count : CW'(CAPACITY - 1);

  // Compare the streamed entry against the request key
  assign key_ge = {rdata.key_primary, rdata.key_secondary} >=
                  {req.key_primary, req.key_secondary};
  assign key_eq = {rdata.key_primary, rdata.key_secondary} ==
                  {req.key_primary, req.key_secondary};

  // Pick the read address
  always_comb begin
    if (cmd.read_idx) begin
      rd_addr = index_x[AW-1:0];
    end else if (cmd.step_down) begin
      rd_addr = AW'(idx - CW'(1));
    end else begin
      rd_addr = idx[AW-1:0];
    end
  end

  // Pick the write port: new entry at its slot, or a shifted neighbor
  always_comb begin
    wr_en = cmd.write_new | (cmd.shift_wr & rvalid);
    if (cmd.write_new) begin
      wr_addr = pos[AW-1:0];
      wr_data = '{key_primary: req.key_primary, key_secondary: req.key_secondary,
                  percent: req.entry_percent};
    end else begin
      wr_addr = cmd.step_up ? (rv_addr - AW'(1)) : (rv_addr + AW'(1));
      wr_data = rdata;
    end
  end

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // Track whether the read data belongs to the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else if (cmd.step_up) begin
      rvalid <= idx < count;
    end else if (cmd.step_down) begin
      rvalid <= idx > pos;
    end else begin
      rvalid <= 1'b0;
    end
  end

  // Advance the walk index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= '0;
    end else if (cmd.prep_remove) begin
      idx <= pos + CW'(1);
    end else if (cmd.prep_insert) begin
      idx <= last;
    end else if (cmd.step_up && (idx < count)) begin
      idx <= idx + CW'(1);
      rv_addr <= idx[AW-1:0];
    end else if (cmd.step_down && (idx > pos)) begin
      idx <= idx - CW'(1);
      rv_addr <= AW'(idx - CW'(1));
    end
  end

  // Saturate the percent of the incoming request
  always_comb begin
    req_in = request;
    if (request.entry_percent > PCT_MAX) begin
      req_in.entry_percent = PCT_MAX;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_in;
    end
  end

  // Record where the scan stopped
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      match <= 1'b0;
    end else if (cmd.cmp_en) begin
      if (rvalid && key_ge) begin
        pos <= CW'(rv_addr);
        match <= key_eq;
        found <= rdata;
      end else if (!rvalid && (idx >= count)) begin
        pos <= count;
        match <= 1'b0;
      end
    end
  end

  // Hold the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc && (count < CW'(CAPACITY))) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  // Report status to the controller
  always_comb begin
    sts.scan_found = rvalid & key_ge;
    sts.up_end     = !rvalid && (idx >= count);
    sts.down_end   = !rvalid && (idx <= pos);
    sts.match      = match;
    sts.pos_full   = pos == CW'(CAPACITY);
    sts.command    = req.command;
  end

  // Build the result of the finished request
  always_comb begin
    res_next = '0;
    res_next.entry_count = CNT_OUT_W'(count);
    case (req.command)
      CMD_TOGGLE: begin
        res_next.hit = !match;
      end
      CMD_FIND: begin
        if (match) begin
          res_next.hit = 1'b1;
          res_next.out_primary = found.key_primary;
          res_next.out_secondary = found.key_secondary;
          res_next.out_percent = found.percent;
        end
      end
      CMD_READ: begin
        if (index_ok) begin
          res_next.hit = 1'b1;
          res_next.out_primary = rdata.key_primary;
          res_next.out_secondary = rdata.key_secondary;
          res_next.out_percent = rdata.percent;
        end
      end
      default: begin
        res_next.hit = 1'b0;
      end
    endcase
  end

  // Register the result and its strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result <= res_next;
    end
  end

  `ASSERT_NEXT(a_done_follows_emit, clk, rst, cmd.emit, done, "result strobe missing after emit")
  `ASSERT_NEXT(a_done_only_after_emit, clk, rst, !cmd.emit, !done, "result strobe without emit")
  `ASSERT_SAME(a_write_in_range, clk, rst, wr_en, CW'(wr_addr) < CW'(CAPACITY), "write beyond table")
  `ASSERT_NEXT(a_count_holds, clk, rst, !(cmd.cnt_inc || cmd.cnt_dec), $stable(count), "count moved without update")

endmodule

>>> tb/sorted_key_toggle_table_unit_tb.sv
// Self-checking testbench for the sorted key toggle table unit
`timescale 1ns / 1ps

module sorted_key_toggle_table_unit_tb;
  import sktt_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;
  localparam int MAX_REPORTS = 10;

  // Predicts each result from its own copy of the sorted table
  class toggle_table_scoreboard;
    entry_t entries [TABLE_DEPTH];
    int unsigned fill = 0;
    res_t expected_q [$];
    int unsigned errors = 0;

    // True when key (p, s) orders strictly ahead of entry e
    function bit key_less(logic [KEY_W-1:0] p, logic [KEY_W-1:0] s, entry_t e);
      if (p != e.key_primary) return p < e.key_primary;
      return s < e.key_secondary;
    endfunction

    // Slot holding key (p, s), or fill when absent
    function int unsigned find_slot(logic [KEY_W-1:0] p, logic [KEY_W-1:0] s);
      for (int unsigned i = 0; i < fill; i++) begin
        if (entries[i].key_primary == p && entries[i].key_secondary == s) return i;
      end
      return fill;
    endfunction

    // Close the gap at pos
    function void remove_slot(int unsigned pos);
      for (int unsigned i = pos; i + 1 < fill; i++) entries[i] = entries[i + 1];
      fill--;
    endfunction

    // Open a gap at the sorted position; the largest key falls off a full table
    function void insert_sorted(entry_t e);
      int unsigned pos;
      int unsigned last;
      pos = 0;
      while (pos < fill && !key_less(e.key_primary, e.key_secondary, entries[pos])) pos++;
      if (pos >= TABLE_DEPTH) return;
      last = (fill < TABLE_DEPTH) ? fill : TABLE_DEPTH - 1;
      for (int unsigned i = last; i > pos; i--) entries[i] = entries[i - 1];
      entries[pos] = e;
      if (fill < TABLE_DEPTH) fill++;
    endfunction

    // Apply an accepted request and queue the result it must produce
    function void note_request(req_t r);
      res_t exp_res;
      entry_t e;
      int unsigned pos;
      exp_res = '0;
      e.key_primary = r.key_primary;
      e.key_secondary = r.key_secondary;
      e.percent = (r.entry_percent > PCT_MAX) ? PCT_MAX : r.entry_percent;
      case (r.command)
        CMD_TOGGLE: begin
          pos = find_slot(r.key_primary, r.key_secondary);
          if (pos < fill) begin
            remove_slot(pos);
          end else begin
            insert_sorted(e);
            exp_res.hit = 1'b1;
          end
        end
        CMD_FIND: begin
          pos = find_slot(r.key_primary, r.key_secondary);
          if (pos < fill) begin
            exp_res.hit = 1'b1;
            exp_res.out_primary = entries[pos].key_primary;
            exp_res.out_secondary = entries[pos].key_secondary;
            exp_res.out_percent = entries[pos].percent;
          end
        end
        CMD_READ: begin
          if (r.entry_index < fill) begin
            exp_res.hit = 1'b1;
            exp_res.out_primary = entries[r.entry_index].key_primary;
            exp_res.out_secondary = entries[r.entry_index].key_secondary;
            exp_res.out_percent = entries[r.entry_index].percent;
          end
        end
        default: ;
      endcase
      exp_res.entry_count = fill[CNT_OUT_W-1:0];
      expected_q = {expected_q, exp_res};
    endfunction

    // Compare a result with the oldest expectation
    function void check_result(res_t got);
      res_t exp_res;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result hit=%0b p=%0h s=%0h pct=%0d cnt=%0d", $realtime,
                   got.hit, got.out_primary, got.out_secondary, got.out_percent,
                   got.entry_count);
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.hit !== exp_res.hit || got.out_primary !== exp_res.out_primary ||
          got.out_secondary !== exp_res.out_secondary ||
          got.out_percent !== exp_res.out_percent ||
          got.entry_count !== exp_res.entry_count) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: mismatch expected hit=%0b p=%0h s=%0h pct=%0d cnt=%0d", $realtime,
                   exp_res.hit, exp_res.out_primary, exp_res.out_secondary,
                   exp_res.out_percent, exp_res.entry_count);
          $display("%0t:          actual   hit=%0b p=%0h s=%0h pct=%0d cnt=%0d", $realtime,
                   got.hit, got.out_primary, got.out_secondary, got.out_percent,
                   got.entry_count);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t request = '0;
  logic done;
  res_t result;

  toggle_table_scoreboard sb;

  sorted_key_toggle_table_unit #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Check every strobed result
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(result);
  end

  // Hold start until the request is taken, then note it
  task automatic send_request(req_t r);
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(r);
  endtask

  // Drop start and let the clock run idle
  task automatic idle_cycles(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every expected result has come
  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic req_t make_req(logic [1:0] cmd, logic [KEY_W-1:0] p,
                                    logic [KEY_W-1:0] s, logic [PCT_W-1:0] pct,
                                    logic [IDX_W-1:0] idx);
    req_t r;
    r.command = cmd;
    r.key_primary = p;
    r.key_secondary = s;
    r.entry_percent = pct;
    r.entry_index = idx;
    return r;
  endfunction

  // Key words that collide often and sit at the extremes
  function automatic logic [KEY_W-1:0] pool_word();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFE;
      3: return '1;
      default: return $urandom_range(0, 7);
    endcase
  endfunction

  function automatic req_t random_request(int unsigned toggle_pct, int unsigned present_pct);
    req_t r;
    int unsigned roll;
    int unsigned slot;
    roll = $urandom_range(0, 99);
    if (roll < toggle_pct) r.command = CMD_TOGGLE;
    else if (roll < 97) r.command = ($urandom_range(0, 1) == 0) ? CMD_FIND : CMD_READ;
    else r.command = CMD_UNUSED;
    roll = $urandom_range(0, 99);
    if (sb.fill != 0 && roll < present_pct) begin
      slot = $urandom_range(0, sb.fill - 1);
      r.key_primary = sb.entries[slot].key_primary;
      r.key_secondary = sb.entries[slot].key_secondary;
    end else begin
      r.key_primary = ($urandom_range(0, 1) == 0) ? pool_word() : $urandom();
      r.key_secondary = ($urandom_range(0, 1) == 0) ? pool_word() : $urandom();
    end
    r.entry_percent = PCT_W'($urandom_range(0, 127));
    if (sb.fill != 0 && $urandom_range(0, 1) == 0)
      r.entry_index = IDX_W'($urandom_range(0, (sb.fill > 127) ? 127 : sb.fill));
    else
      r.entry_index = IDX_W'($urandom_range(0, 127));
    return r;
  endfunction

  // Random requests, with idle bursts except in quiet stretches
  task automatic run_phase(int unsigned n, int unsigned toggle_pct,
                           int unsigned present_pct, bit allow_idle);
    bit quiet;
    quiet = 1'b1;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 32 == 0) quiet = !allow_idle || ($urandom_range(0, 2) == 0);
      send_request(random_request(toggle_pct, present_pct));
      if (!quiet && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 17));
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, extremes, saturation, ties, misses, removal to empty
    send_request(make_req(CMD_READ, '0, '0, '0, 7'd0));
    send_request(make_req(CMD_FIND, '0, '0, '0, '0));
    send_request(make_req(CMD_TOGGLE, '0, '0, 7'd0, '0));
    send_request(make_req(CMD_TOGGLE, '1, '1, 7'd127, '1));
    send_request(make_req(CMD_TOGGLE, 32'd5, '1, 7'd100, '0));
    send_request(make_req(CMD_TOGGLE, 32'd5, '0, 7'd101, '0));
    send_request(make_req(CMD_TOGGLE, '1, '0, 7'd50, '0));
    send_request(make_req(CMD_FIND, 32'd5, '0, '0, '0));
    send_request(make_req(CMD_FIND, 32'd5, 32'd1, '0, '0));
    send_request(make_req(CMD_FIND, '1, '1, '1, '1));
    send_request(make_req(CMD_READ, '0, '0, '0, 7'd0));
    send_request(make_req(CMD_READ, '0, '0, '0, 7'd4));
    send_request(make_req(CMD_READ, '0, '0, '0, 7'd5));
    send_request(make_req(CMD_READ, '1, '1, '1, 7'd127));
    send_request(make_req(CMD_UNUSED, '1, '1, '1, '1));
    send_request(make_req(CMD_TOGGLE, 32'd5, '0, 7'd20, '0));
    send_request(make_req(CMD_TOGGLE, '1, '1, 7'd20, '0));
    send_request(make_req(CMD_TOGGLE, '0, '0, 7'd20, '0));
    send_request(make_req(CMD_READ, '0, '0, '0, 7'd0));
    send_request(make_req(CMD_TOGGLE, 32'd5, '1, 7'd20, '0));
    send_request(make_req(CMD_TOGGLE, '1, '0, 7'd20, '0));
    send_request(make_req(CMD_FIND, '1, '0, '0, '0));
    send_request(make_req(CMD_UNUSED, '0, '0, '0, '0));
    drain_results();

    // Fill past capacity, then churn a full table
    run_phase(220, 85, 5, 1'b1);
    drain_results();
    run_phase(200, 60, 30, 1'b1);
    // Shrink toward empty by removing present keys
    run_phase(150, 90, 95, 1'b1);
    // Mixed traffic, then a final stretch without idling
    run_phase(300, 50, 45, 1'b1);
    run_phase(80, 50, 45, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) $display("%0d requests left without a result", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #12_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/sktt_pkg.sv
src/sktt_ctrl.sv
src/sktt_datapath.sv
src/sorted_key_toggle_table_unit.sv
tb/sorted_key_toggle_table_unit_tb.sv
